@@ rtl/imh_pkg.sv @@
package imh_pkg;

	localparam logic [1:0] OP_PUSH     = 2'd0;
	localparam logic [1:0] OP_POP      = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic ST_OK        = 1'b0;
	localparam logic ST_POP_EMPTY = 1'b1;

	typedef struct packed {
		logic [1:0]         operation;
		logic [11:0]        item_index;
		logic signed [31:0] item_value;
	} cmd_t;

	typedef struct packed {
		logic [11:0]        removed_index;
		logic signed [31:0] removed_value;
		logic [11:0]        root_index;
		logic signed [31:0] root_value;
		logic [12:0]        entry_count;
		logic               is_empty;
		logic               status;
	} rsp_t;

endpackage

@@ rtl/indexed_min_heap_decrease_key_top.sv @@
// Indexed binary min-heap with decrease-key. Push sifts the entry up level by level and
// changes nothing when the heap is full, the index is out of range or the value is not lower;
// pop sifts the last entry down from the root; pop on an empty heap or an unused code only
// reports; clear sweeps the position map. One item at a time: busy is high until the strobe.
// Reset: clears the fill count, then sweeps all CAPACITY position map entries
// with busy high. The receiver cannot stall; the done strobe is high for one cycle.
module indexed_min_heap_decrease_key_top #(
	parameter int CAPACITY   = 4096,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  imh_pkg::cmd_t        cmd,
	output logic                 done,
	output imh_pkg::rsp_t        rsp
);

	localparam int AW = $clog2(CAPACITY + 1);   // slot address / count width
	localparam int IW = 12;
	localparam int VW = VALUE_BITS;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PM    = 4'd2;
	localparam logic [3:0] S_PMW   = 4'd3;
	localparam logic [3:0] S_UPRD  = 4'd4;
	localparam logic [3:0] S_UPCMP = 4'd5;
	localparam logic [3:0] S_DNRD  = 4'd6;
	localparam logic [3:0] S_DNR2  = 4'd7;
	localparam logic [3:0] S_DNCMP = 4'd8;
	localparam logic [3:0] S_POPRD = 4'd9;
	localparam logic [3:0] S_POPW  = 4'd10;
	localparam logic [3:0] S_ROOT  = 4'd11;
	localparam logic [3:0] S_ROOTW = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	// heap slots and position map
	logic [IW-1:0] slot_idx_mem [CAPACITY+1];
	logic [VW-1:0] slot_val_mem [CAPACITY+1];
	logic [AW-1:0] pos_mem [CAPACITY];

	logic [3:0]    state_q;
	logic [AW-1:0] fill_q, pos_q, other_q, clr_q;
	logic [1:0]    op_q;
	logic [IW-1:0] idx_q, cur_idx_q, oth_idx_q, rem_idx_q;
	logic [VW-1:0] val_q, cur_val_q, oth_val_q, rem_val_q;
	logic          status_q, done_q;
	logic [IW-1:0] root_idx_q;
	logic [VW-1:0] root_val_q;

	// one read port per memory, registered
	logic [AW-1:0] srd_addr;
	logic [IW-1:0] srd_idx_q;
	logic [VW-1:0] srd_val_q;
	logic [IW-1:0] prd_addr;
	logic [AW-1:0] prd_q;

	// one write port per memory
	logic          swe, pwe;
	logic [AW-1:0] swa, pwd;
	logic [IW-1:0] swi, pwa;
	logic [VW-1:0] swv;

	// shared signed compare: a < b
	logic [VW-1:0] cmp_a, cmp_b;
	logic          cmp_lt;
	assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

	logic idx_ok;
	assign idx_ok = {1'b0, idx_q} < (IW+1)'(CAPACITY);

	logic [AW:0] child_w;
	assign child_w = {pos_q, 1'b0};

	always_ff @(posedge clk) begin
		srd_idx_q <= slot_idx_mem[srd_addr];
		srd_val_q <= slot_val_mem[srd_addr];
		prd_q     <= pos_mem[prd_addr[$clog2(CAPACITY)-1:0]];
		if (swe) begin
			slot_idx_mem[swa] <= swi;
			slot_val_mem[swa] <= swv;
		end
		if (pwe)
			pos_mem[pwa[$clog2(CAPACITY)-1:0]] <= pwd;
	end

	// datapath control
	always_comb begin
		srd_addr = pos_q;
		prd_addr = idx_q;
		swe = 1'b0; swa = pos_q; swi = cur_idx_q; swv = cur_val_q;
		pwe = 1'b0; pwa = cur_idx_q; pwd = pos_q;
		cmp_a = cur_val_q; cmp_b = srd_val_q;
		unique case (state_q)
			S_CLR: begin
				pwe = 1'b1; pwa = clr_q[IW-1:0]; pwd = '0;
			end
			S_IDLE: begin
				prd_addr = cmd.item_index;
				srd_addr = AW'(1);
			end
			S_PM: srd_addr = prd_q;
			S_PMW: begin
				cmp_a = val_q;
				if (prd_q == '0) begin
					swe = (fill_q < AW'(CAPACITY)) && idx_ok;
					swa = fill_q + AW'(1); swi = idx_q; swv = val_q;
					pwe = swe; pwa = idx_q; pwd = fill_q + AW'(1);
				end else begin
					swe = cmp_lt && idx_ok;
					swa = prd_q; swi = idx_q; swv = val_q;
				end
			end
			S_UPRD: srd_addr = pos_q >> 1;
			S_UPCMP: begin
				cmp_a = cur_val_q; cmp_b = srd_val_q;
				if (pos_q > AW'(1) && cmp_lt) begin
					// move parent down into pos
					swe = 1'b1; swa = pos_q; swi = srd_idx_q; swv = srd_val_q;
					pwe = 1'b1; pwa = srd_idx_q; pwd = pos_q;
				end else begin
					swe = 1'b1; swa = pos_q;
					pwe = 1'b1; pwa = cur_idx_q; pwd = pos_q;
				end
			end
			S_POPRD: srd_addr = fill_q;
			S_POPW: begin
				pwe = 1'b1; pwa = rem_idx_q; pwd = '0;
			end
			S_DNRD: srd_addr = child_w[AW-1:0];
			S_DNR2: srd_addr = child_w[AW-1:0] + AW'(1);
			S_ROOTW: begin
				// right child against the left one
				cmp_a = srd_val_q; cmp_b = oth_val_q;
			end
			S_DNCMP: begin
				// other_q/oth_* hold chosen child, or the moving entry at a leaf
				cmp_a = oth_val_q; cmp_b = cur_val_q;
				if (cmp_lt) begin
					swe = 1'b1; swa = pos_q; swi = oth_idx_q; swv = oth_val_q;
					pwe = 1'b1; pwa = oth_idx_q; pwd = pos_q;
				end else begin
					swe = 1'b1; swa = pos_q;
					pwe = 1'b1; pwa = cur_idx_q; pwd = pos_q;
				end
			end
			S_ROOT: srd_addr = AW'(1);
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
			op_q    <= imh_pkg::OP_PUSH;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (clr_q == AW'(CAPACITY - 1)) begin
						state_q <= (op_q == imh_pkg::OP_CLEAR) ? S_ROOT : S_IDLE;
						clr_q <= '0;
					end else
						clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (start) begin
						op_q      <= cmd.operation;
						idx_q     <= cmd.item_index;
						val_q     <= VW'(cmd.item_value);
						rem_idx_q <= '0;
						rem_val_q <= '0;
						status_q  <= imh_pkg::ST_OK;
						unique case (cmd.operation)
							imh_pkg::OP_PUSH: state_q <= S_PM;
							imh_pkg::OP_POP: begin
								if (fill_q == '0) begin
									status_q <= imh_pkg::ST_POP_EMPTY;
									state_q  <= S_ROOT;
								end else
									state_q <= S_POPRD;
							end
							imh_pkg::OP_CLEAR: begin
								fill_q  <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_ROOT;
						endcase
					end
				end
				S_PM: state_q <= S_PMW;
				S_PMW: begin
					cur_idx_q <= idx_q;
					cur_val_q <= val_q;
					if (!swe)
						state_q <= S_ROOT;
					else begin
						state_q <= S_UPRD;
						if (prd_q == '0) begin
							fill_q <= fill_q + AW'(1);
							pos_q  <= fill_q + AW'(1);
						end else
							pos_q <= prd_q;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (pos_q > AW'(1) && cmp_lt) begin
						pos_q   <= pos_q >> 1;
						state_q <= S_UPRD;
					end else
						state_q <= S_ROOT;
				end
				S_POPRD: begin
					// root still in read register from idle
					rem_idx_q <= srd_idx_q;
					rem_val_q <= srd_val_q;
					state_q   <= S_POPW;
				end
				S_POPW: begin
					cur_idx_q <= srd_idx_q;
					cur_val_q <= srd_val_q;
					fill_q    <= fill_q - AW'(1);
					pos_q     <= AW'(1);
					state_q   <= (fill_q == AW'(1)) ? S_ROOT : S_DNRD;
				end
				S_DNRD: begin
					if (child_w > {1'b0, fill_q}) begin
						// leaf: write back the moving entry
						state_q <= S_DNCMP;
						oth_val_q <= cur_val_q;
						oth_idx_q <= cur_idx_q;
					end else
						state_q <= S_DNR2;
				end
				S_DNR2: begin
					oth_idx_q <= srd_idx_q;
					oth_val_q <= srd_val_q;
					other_q   <= child_w[AW-1:0];
					// reuse S_ROOTW as the right-child compare step
					state_q   <= (child_w < {1'b0, fill_q}) ? S_ROOTW : S_DNCMP;
				end
				S_ROOTW: begin
					// right child in read register
					if (cmp_lt) begin
						oth_idx_q <= srd_idx_q;
						oth_val_q <= srd_val_q;
						other_q   <= child_w[AW-1:0] + AW'(1);
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (cmp_lt) begin
						pos_q   <= other_q;
						state_q <= S_DNRD;
					end else
						state_q <= S_ROOT;
				end
				S_ROOT: state_q <= S_DONE;
				S_DONE: begin
					root_idx_q <= srd_idx_q;
					root_val_q <= srd_val_q;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	always_comb begin
		rsp.removed_index = rem_idx_q;
		rsp.removed_value = 32'(rem_val_q);
		rsp.root_index    = (fill_q == '0) ? '0 : root_idx_q;
		rsp.root_value    = (fill_q == '0) ? '0 : 32'(root_val_q);
		rsp.entry_count   = 13'(fill_q);
		rsp.is_empty      = fill_q == '0;
		rsp.status        = status_q;
	end

endmodule
